### rtl/core/job_handle_deque_core_defines.svh
// assertion macros for the job handle deque core
// used by job_handle_deque_core.sv, expects aclk and aresetn in scope
`ifndef JOB_HANDLE_DEQUE_CORE_DEFINES_SVH
`define JOB_HANDLE_DEQUE_CORE_DEFINES_SVH

// checked only while out of reset
`define JHD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define JHD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/core/jhd_pkg.sv
// shared types and constants for the job handle deque core
// no dependencies
`default_nettype none

package jhd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_NAMED = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_REAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY        = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [HANDLE_BITS-1:0] job_handle;
    } jhd_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [HANDLE_BITS-1:0] removed_handle;
        logic [CNT_W-1:0]       entry_total;
    } jhd_out_t;

endpackage

`default_nettype wire

### rtl/core/job_handle_deque_core.sv
// append, refused or empty-queue beats give a result in the cycle after accept
// search: each entry examined takes a memory read (S_FETCH) and then a compare (S_EVAL)
// removal moves each later entry forward with a read (S_SFETCH) and a write (S_SWRITE), then closes in S_SFETCH
// no new beat is taken until the result has left; s_ready returns in the cycle after it leaves
// the entry memory has one write port and one registered read port, so each moved entry is read, then written
// reset clears the count and control state; entry storage is not cleared
`default_nettype none
`include "job_handle_deque_core_defines.svh"

module job_handle_deque_core
    import jhd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire jhd_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output jhd_out_t      m_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_EVAL   = 6'b000100,
        S_SFETCH = 6'b001000,
        S_SWRITE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [HANDLE_BITS-1:0] removed_reg, removed_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic [HANDLE_BITS-1:0] mem [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [HANDLE_BITS-1:0] wr_data;

    logic [CNT_W-1:0]       idx_inc;
    logic                   hit;
    logic                   append_full;

    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);
    // end removals take whatever sits at the index, others need an equal handle
    assign hit = (op_reg == OP_REMOVE_FRONT) || (op_reg == OP_REMOVE_REAR) ||
                 (rd_data_reg == handle_reg);
    assign rd_addr = (state_reg == S_SFETCH) ? (idx_reg + IDX_W'(1)) : idx_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        handle_next  = handle_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = rd_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_data.operation;
                    handle_next  = s_data.job_handle;
                    removed_next = '0;
                    status_next  = ST_EMPTY;
                    idx_next     = '0;
                    state_next   = S_DONE;
                    unique case (s_data.operation)
                        OP_APPEND: begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                wr_en       = 1'b1;
                                wr_addr     = count_reg[IDX_W-1:0];
                                wr_data     = s_data.job_handle;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ST_OK;
                            end
                        end
                        OP_REMOVE_NAMED, OP_QUERY, OP_REMOVE_FRONT: begin
                            if (count_reg != '0) begin
                                state_next = S_FETCH;
                            end
                        end
                        OP_REMOVE_REAR: begin
                            if (count_reg != '0) begin
                                idx_next   = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_FETCH;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (hit) begin
                    status_next = ST_OK;
                    if (op_reg == OP_QUERY) begin
                        state_next = S_DONE;
                    end else begin
                        removed_next = rd_data_reg;
                        state_next   = S_SFETCH;
                    end
                end else if (idx_inc == count_reg) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_FETCH;
                end
            end
            S_SFETCH: begin
                // close the gap one entry at a time
                if (idx_inc >= count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    state_next = S_SWRITE;
                end
            end
            S_SWRITE: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data_reg;
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_SFETCH;
            end
            S_DONE: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg     <= idx_next;
        op_reg      <= op_next;
        handle_reg  <= handle_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_DONE);

    assign m_data.status         = status_reg;
    assign m_data.removed_handle = removed_reg;
    assign m_data.entry_total    = count_reg;

    assign append_full = s_valid && s_ready && (s_data.operation == OP_APPEND) &&
                         (count_reg == CNT_W'(QUEUE_DEPTH));

    `JHD_ASSERT(a_count_in_range, count_reg <= CNT_W'(QUEUE_DEPTH), "entry count beyond depth")
    `JHD_ASSERT_ALWAYS(a_one_side_open, !aresetn || !(s_ready && m_valid), "both sides open")
    `JHD_ASSERT(a_shift_in_queue, (state_reg == S_SWRITE) |-> (idx_inc < count_reg), "bad shift")
    `JHD_ASSERT(a_full_keeps_count, append_full |=> $stable(count_reg), "full append moved count")

endmodule

`default_nettype wire
